// ----- rtl/sdpd_pkg.sv -----
// Package for the six-axis serial packet decoder.
// Holds the packet framing constants and the code character table.
// No dependencies.
package sdpd_pkg;

  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] TYPE_AXIS   = 8'h64;
  localparam logic [7:0] TYPE_BUTTON = 8'h6B;

  localparam int AXIS_PACKET_LEN   = 25;
  localparam int BUTTON_PACKET_LEN = 4;
  localparam int NUM_AXES          = 6;
  localparam int AXIS_W            = 16;
  localparam int BUTTON_W          = 9;
  localparam int NIB_W             = 4;
  localparam int ACC_W             = NUM_AXES * AXIS_W;

  // Map a low nibble to the only byte that may carry it.
  function automatic logic [7:0] code_char(input logic [3:0] nib);
    logic [7:0] c;
    unique case (nib)
      4'h0: c = 8'h30;  // '0'
      4'h1: c = 8'h41;  // 'A'
      4'h2: c = 8'h42;  // 'B'
      4'h3: c = 8'h33;  // '3'
      4'h4: c = 8'h44;  // 'D'
      4'h5: c = 8'h35;  // '5'
      4'h6: c = 8'h36;  // '6'
      4'h7: c = 8'h47;  // 'G'
      4'h8: c = 8'h48;  // 'H'
      4'h9: c = 8'h39;  // '9'
      4'hA: c = 8'h3A;  // ':'
      4'hB: c = 8'h4B;  // 'K'
      4'hC: c = 8'h3C;  // '<'
      4'hD: c = 8'h4D;  // 'M'
      4'hE: c = 8'h4E;  // 'N'
      default: c = 8'h3F;  // '?'
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/sixdof_serial_packet_decoder_unit.sv -----
// Six-axis controller serial packet decoder, top level.
// Depends on sdpd_pkg and sdpd_ram.
//
// Usage:
//   Input channel (rx_byte, in_valid, in_stall) takes one received serial
//   byte per request. Non-CR bytes are written to the packet buffer and
//   may come back to back; bytes past BUFFER_DEPTH are dropped.
//   A carriage return ends the packet: a packet of the right type and length
//   is walked one code byte at a time through the single buffer read port
//   and one code compare; each code byte is read, then checked.
//   Such a CR holds in_stall high through the walk of 24 code bytes on an
//   axis packet or 3 on a button packet, and while the finished report
//   waits for a stalled output register; a bad code byte ends the walk early.
//   Any other CR is taken without a stall and gives no report.
//   Output channel (out_valid, out_stall, report_kind and the report fields)
//   carries at most one report per packet from an output register; the
//   input side keeps taking bytes while a report waits. Reset empties the
//   buffer count, drops any pending report and returns the sequencer to idle;
//   buffer contents are not cleared.
module sixdof_serial_packet_decoder_unit
  import sdpd_pkg::*;
#(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [7:0]                 rx_byte,
  input  logic                       in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       report_kind,
  output logic signed [AXIS_W-1:0]   axis_x,
  output logic signed [AXIS_W-1:0]   axis_y,
  output logic signed [AXIS_W-1:0]   axis_z,
  output logic signed [AXIS_W-1:0]   axis_rx,
  output logic signed [AXIS_W-1:0]   axis_ry,
  output logic signed [AXIS_W-1:0]   axis_rz,
  output logic [BUTTON_W-1:0]        button_bits
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state;
  logic [CW-1:0]    byte_count;
  logic [7:0]       pkt_type;
  logic             is_button;
  logic [AW-1:0]    idx;
  logic [AW-1:0]    last;
  logic [ACC_W-1:0] acc;
  logic [7:0]       rdata;
  logic             in_take;
  logic             is_cr;
  logic             wr_en;
  logic             out_free;
  logic [BUTTON_W-1:0] btn_next;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign is_cr    = (rx_byte == CHAR_CR);
  assign wr_en    = in_take && !is_cr && (byte_count < CW'(BUFFER_DEPTH));
  assign out_free = !out_valid || !out_stall;

  // Button word: (n1 << 1) | (n2 << 5) | n3
  assign btn_next = {acc[7:4], 5'b0} | {4'b0, acc[11:8], 1'b0} | {5'b0, acc[3:0]};

  sdpd_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_buf (
    .clk  (clk),
    .we   (wr_en),
    .waddr(byte_count[AW-1:0]),
    .wdata(rx_byte),
    .raddr(idx),
    .rdata(rdata)
  );

  // Sequencer: collect bytes, walk code bytes on CR, post report
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      byte_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // Raise valid for a finished report, drop it once the report is taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (is_cr) begin
              byte_count <= '0;
              idx        <= AW'(1);
              if (pkt_type == TYPE_AXIS && byte_count == CW'(AXIS_PACKET_LEN)) begin
                is_button <= 1'b0;
                last      <= AW'(AXIS_PACKET_LEN - 1);
                state     <= S_READ;
              end else if (pkt_type == TYPE_BUTTON &&
                           byte_count == CW'(BUTTON_PACKET_LEN)) begin
                is_button <= 1'b1;
                last      <= AW'(BUTTON_PACKET_LEN - 1);
                state     <= S_READ;
              end
            end else if (wr_en) begin
              if (byte_count == '0) begin
                pkt_type <= rx_byte;
              end
              byte_count <= byte_count + CW'(1);
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          // Drop the packet on a bad code byte, else shift in its nibble
          if (rdata != code_char(rdata[3:0])) begin
            state <= S_IDLE;
          end else begin
            acc <= {acc[ACC_W-NIB_W-1:0], rdata[3:0]};
            if (idx == last) begin
              state <= S_DONE;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_READ;
            end
          end
        end
        S_DONE: begin
          // Hold until the output register is free
          if (out_free) begin
            report_kind <= is_button;
            if (is_button) begin
              axis_x      <= '0;
              axis_y      <= '0;
              axis_z      <= '0;
              axis_rx     <= '0;
              axis_ry     <= '0;
              axis_rz     <= '0;
              button_bits <= btn_next;
            end else begin
              axis_x      <= {~acc[95], acc[94:80]};
              axis_y      <= {~acc[79], acc[78:64]};
              axis_z      <= {~acc[63], acc[62:48]};
              axis_rx     <= {~acc[47], acc[46:32]};
              axis_ry     <= {~acc[31], acc[30:16]};
              axis_rz     <= {~acc[15], acc[14:0]};
              button_bits <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/sdpd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
